### rtl/integer_alu_mul_div_top_assert.svh
// Assertion macros for the integer ALU block.
// Used by the port checker; no other dependencies.
`ifndef INTEGER_ALU_MUL_DIV_TOP_ASSERT_SVH
`define INTEGER_ALU_MUL_DIV_TOP_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define IAMD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define IAMD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

### rtl/iamd_pkg.sv
// Package for the integer ALU: operation codes, widths, queue entry type.
// No dependencies.
package iamd_pkg;
   localparam int DataWidth = 32;
   localparam int QueueDepth = 2;
   localparam int DivStages = 32;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL_LO = 3'd2, OP_MUL_HS = 3'd3,
      OP_MUL_HU = 3'd4, OP_DIV = 3'd5, OP_MOD = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } entry_type;
endpackage

### rtl/integer_alu_mul_div_top.sv
// Top level of the 32-bit integer ALU with multiply and divide.
// Depends on iamd_pkg, iamd_front and iamd_back.
//
// Requests (req_type, operand_a, operand_b) enter on req_valid/req_ready.
// Results (result_value, divide_by_zero) leave on rsp_valid/rsp_ready,
// one per request, in request order.
// The front queue holds two requests; the back is a fixed pipeline of
// 34 stages: an operand stage that also forms the 64-bit product, a
// stage per quotient bit of the restoring divider (32), and a result
// select stage. Every operation takes the same path: the queue, then
// every stage. Throughput is one request per cycle unless a waiting
// result holds the pipeline, set by the one-bit-per-stage divider that
// lets a new divide enter every cycle.
// Reset clears the queue and all stage valid bits; no result is pending.
// While a result waits with rsp_ready low the whole pipeline holds; the
// queue keeps taking requests until full, then req_ready drops.
module integer_alu_mul_div_top import iamd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] result_value,
   output logic        divide_by_zero
);
   logic      q_valid, q_ready;
   entry_type q_entry;

   // accept requests into the queue
   iamd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .operand_a,
      .operand_b, .q_valid, .q_ready, .q_entry
   );

   // execute and hold results for the receiver
   iamd_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_entry, .rsp_valid, .rsp_ready,
      .result_value, .divide_by_zero
   );
endmodule

### rtl/iamd_front.sv
// Front part: accepts requests into a small queue.
// Depends on iamd_pkg.
module iamd_front import iamd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic        q_valid,
   input  logic        q_ready,
   output entry_type   q_entry
);
   entry_type  mem_ff [QueueDepth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'(QueueDepth));
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_entry   = mem_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;
   assign wp_in  = push ? ~wp_ff : wp_ff;
   assign rp_in  = pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= '{op: req_type, a: operand_a, b: operand_b};
   end
endmodule

### rtl/iamd_back.sv
// Back part: add, subtract, pipelined multiply and restoring divide, one bit per stage.
// Depends on iamd_pkg.
module iamd_back import iamd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  entry_type   q_entry,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] result_value,
   output logic        divide_by_zero
);
   localparam int NS = DivStages + 2;
   // stage 0: input regs; stages 1..32: divide bits; mult done at stage 1,
   // value carried along.
   logic [NS-1:0] v_ff;
   logic [2:0]    op_ff  [NS];
   logic [31:0]   rem_ff [DivStages+1];
   logic [31:0]   quo_ff [DivStages+1];
   logic [31:0]   b_ff   [NS];
   logic [31:0]   a_ff   [NS-1];
   logic [63:0]   prod_ff;
   logic [31:0]   res_ff [1:NS-1];
   logic          adv;
   logic [32:0]   trial [1:DivStages];

   assign adv = !v_ff[NS-1] || rsp_ready;
   assign q_ready = adv;
   assign rsp_valid = v_ff[NS-1];
   assign result_value = res_ff[NS-1];
   assign divide_by_zero = ((op_ff[NS-1] == OP_DIV) || (op_ff[NS-1] == OP_MOD))
                           && (b_ff[NS-1] == 32'd0);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], q_valid};
      if (adv) begin
         op_ff[0] <= q_entry.op;
         a_ff[0] <= q_entry.a;
         b_ff[0] <= q_entry.b;
         rem_ff[0] <= 32'd0;
         quo_ff[0] <= q_entry.a;
         prod_ff <= 64'(q_entry.a) * 64'(q_entry.b);
         for (int s = 1; s < NS; s++) begin
            op_ff[s] <= op_ff[s-1];
            b_ff[s] <= b_ff[s-1];
         end
         for (int s = 1; s < NS - 1; s++)
            a_ff[s] <= a_ff[s-1];
         for (int s = 1; s <= DivStages; s++) begin
            rem_ff[s] <= trial[s][32] ? 32'({rem_ff[s-1], quo_ff[s-1][31]})
                                      : trial[s][31:0];
            quo_ff[s] <= {quo_ff[s-1][30:0], ~trial[s][32]};
         end
         for (int s = 2; s < NS - 1; s++)
            res_ff[s] <= res_ff[s-1];
         // select the final value at the last stage
         case (op_ff[NS-2]) inside
            OP_ADD:    res_ff[NS-1] <= a_ff[NS-2] + b_ff[NS-2];
            OP_SUB:    res_ff[NS-1] <= a_ff[NS-2] - b_ff[NS-2];
            OP_MUL_LO, OP_MUL_HS, OP_MUL_HU: res_ff[NS-1] <= res_ff[NS-2];
            OP_DIV:    res_ff[NS-1] <= (b_ff[NS-2] == 32'd0) ? a_ff[NS-2] : quo_ff[NS-2];
            OP_MOD:    res_ff[NS-1] <= (b_ff[NS-2] == 32'd0) ? a_ff[NS-2] : rem_ff[NS-2];
            default:   res_ff[NS-1] <= 32'd0;
         endcase
         // product registered at stage 0; apply signed fix at stage 1
         case (op_ff[0])
            OP_MUL_LO: res_ff[1] <= prod_ff[31:0];
            OP_MUL_HU: res_ff[1] <= prod_ff[63:32];
            OP_MUL_HS: res_ff[1] <= prod_ff[63:32]
                          - (a_ff[0][31] ? b_ff[0] : 32'd0)
                          - (b_ff[0][31] ? a_ff[0] : 32'd0);
            default:   res_ff[1] <= 32'd0;
         endcase
      end
   end

   always_comb begin
      for (int s = 1; s <= DivStages; s++)
         trial[s] = {1'b0, rem_ff[s-1][30:0], quo_ff[s-1][31]} - {1'b0, b_ff[s-1]}
                    - (rem_ff[s-1][31] ? 33'h1_0000_0000 : 33'd0);
   end
endmodule

### rtl/iamd_checker.sv
// Port checker for the integer ALU top level, bound to it below.
// Depends on integer_alu_mul_div_top_assert.svh.
`include "integer_alu_mul_div_top_assert.svh"
module iamd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] result_value,
   input logic        divide_by_zero
);
   `IAMD_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value), "rsp lost")
   `IAMD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp after reset")
   `IAMD_ASSERT(a_dz_hold, rsp_valid && !rsp_ready |=> $stable(divide_by_zero), "dz moved")
   `IAMD_ASSERT(a_ready_free, rsp_ready && !$past(reset) |-> req_ready || rsp_valid, "stuck")
endmodule

bind integer_alu_mul_div_top iamd_checker u_checker (.*);

### sim/tb_integer_alu_mul_div_top.sv
// Self-checking testbench for the 32-bit integer ALU with multiply and divide.
// Depends on iamd_pkg and integer_alu_mul_div_top; drives directed rows, then random requests.
`timescale 1ns / 100ps

module tb_integer_alu_mul_div_top;
   import iamd_pkg::*;

   localparam int RandomCount = 1750;
   localparam int IdleLimit = 2000;
   localparam int DrainCycles = 60;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } request_type;

   typedef struct {
      logic [31:0] value;
      logic        dz;
      bit          typed;
   } outcome_type;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      bit          typed;
      logic [31:0] value;
      logic        dz;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] result_value;
   logic        divide_by_zero;

   outcome_type expected_results[$];
   request_type request_stream[$];
   int          error_count;
   int          request_count;
   int          result_count;
   int          idle_cycles;
   int          dz_count;
   bit          timed_out;
   bit          steady_phase;

   integer_alu_mul_div_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .result_value(result_value), .divide_by_zero(divide_by_zero)
   );

   // Directed rows: extremes, every operation, zero divisor, signed high
   // multiply corners and the unused opcode. Typed-in values only where obvious.
   row_type directed_rows[] = '{
      '{OP_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_SUB,    32'h0000_0000, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{OP_SUB,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_MUL_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0},
      '{OP_MUL_LO, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, 1'b0},
      '{OP_MUL_HU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b0},
      '{OP_MUL_HU, 32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0001, 1'b0},
      '{OP_MUL_HS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_MUL_HS, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000, 1'b0},
      '{OP_MUL_HS, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{OP_MUL_HS, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{OP_MUL_HS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{OP_DIV,    32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF, 1'b1},
      '{OP_MOD,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{OP_DIV,    32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{OP_DIV,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 1'b0},
      '{OP_DIV,    32'h0000_0005, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_MOD,    32'h0000_0005, 32'hFFFF_FFFF, 1'b1, 32'h0000_0005, 1'b0},
      '{OP_MOD,    32'h8765_4321, 32'h0000_1234, 1'b0, 32'h0, 1'b0},
      '{OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{OP_NONE,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0}
   };

   // Compute the ALU result for one request; signed high word comes from
   // a sign-extended 64-bit product, independent of the unsigned path.
   function automatic outcome_type alu_outcome(request_type r);
      outcome_type o;
      logic signed [63:0] sp;
      logic [63:0]        up;
      o.value = '0;
      o.dz = 1'b0;
      o.typed = 1'b0;
      up = {32'b0, r.a} * {32'b0, r.b};
      sp = $signed({{32{r.a[31]}}, r.a}) * $signed({{32{r.b[31]}}, r.b});
      case (r.op) inside
         OP_ADD:    o.value = r.a + r.b;
         OP_SUB:    o.value = r.a - r.b;
         OP_MUL_LO: o.value = up[31:0];
         OP_MUL_HS: o.value = sp[63:32];
         OP_MUL_HU: o.value = up[63:32];
         OP_DIV, OP_MOD: begin
            if (r.b == 0) begin
               o.value = r.a;
               o.dz = 1'b1;
            end else begin
               o.value = (r.op == OP_DIV) ? r.a / r.b : r.a % r.b;
            end
         end
         default:   o.value = '0;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
      error_count++;
   endtask

   // Draw an operand with a bias toward corners and short values.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 | $urandom_range(0, 3);
         3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         4: return $urandom_range(0, 255);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Build the full request list up front: directed rows, then random.
   initial begin
      request_type r;
      foreach (directed_rows[i]) begin
         r.op = directed_rows[i].op;
         r.a = directed_rows[i].a;
         r.b = directed_rows[i].b;
         request_stream.push_back(r);
      end
      for (int i = 0; i < RandomCount; i++) begin
         r.op = 3'($urandom_range(0, 7));
         r.a = pick_operand();
         r.b = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand();
         request_stream.push_back(r);
      end
   end

   // Request driver: hold valid and payload until accepted, idle ~7% outside
   // the steady stretch.
   initial begin
      int idx;
      request_type r;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= '0;
      operand_a <= '0;
      operand_b <= '0;
      idx = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (idx < request_stream.size()) begin
         @(posedge clock);
         if (req_valid && req_ready) idx++;
         if (req_valid && !req_ready) continue;
         if (idx < request_stream.size() && (steady_phase || $urandom_range(0, 99) >= 7)) begin
            r = request_stream[idx];
            req_valid <= 1'b1;
            req_type <= r.op;
            operand_a <= r.a;
            operand_b <= r.b;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_valid <= 1'b0;
   end

   // Result sink stall pattern; advance into a no-idle stretch mid-run.
   initial begin
      rsp_ready <= 1'b0;
      steady_phase = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         steady_phase = (request_count > 600 && request_count < 900);
         rsp_ready <= steady_phase || ($urandom_range(0, 99) >= 7);
      end
   end

   // Monitor: log accepted requests, compare accepted results, and
   // watch for a stuck pipeline.
   always @(posedge clock) begin
      outcome_type want;
      request_type r;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            r.op = req_type;
            r.a = operand_a;
            r.b = operand_b;
            want = alu_outcome(r);
            if (request_count < directed_rows.size() && directed_rows[request_count].typed) begin
               want.value = directed_rows[request_count].value;
               want.dz = directed_rows[request_count].dz;
               want.typed = 1'b1;
            end
            expected_results.push_back(want);
            request_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", result_value, 32'h0);
            end else begin
               want = expected_results.pop_front();
               if (result_value !== want.value)
                  report_mismatch("result_value", result_value, want.value);
               if (divide_by_zero !== want.dz)
                  report_mismatch("divide_by_zero", {31'b0, divide_by_zero}, {31'b0, want.dz});
               if (divide_by_zero === 1'b1) dz_count++;
            end
            result_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog and end of run.
   initial begin
      timed_out = 1'b0;
      error_count = 0;
      request_count = 0;
      result_count = 0;
      dz_count = 0;
      @(negedge reset);
      while (!(request_count == request_stream.size() && expected_results.size() == 0)
             && !timed_out) begin
         @(posedge clock);
         if (idle_cycles >= IdleLimit) timed_out = 1'b1;
      end
      if (timed_out) begin
         $display("watchdog expired with %0d results pending", expected_results.size());
         $display("FAIL");
         $finish;
      end else begin
         // Let any stray output show up after the last expected result.
         repeat (DrainCycles) @(posedge clock);
         $display("covered %0d requests (%0d directed), %0d results, %0d divide-by-zero",
                  request_count, directed_rows.size(), result_count, dz_count);
         if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
         end else begin
            $display("FAIL");
         end
         $finish;
      end
   end
endmodule
